FILE: src/fbv_pkg.sv
package fbv_pkg;

  localparam int FIELD_W      = 32;
  localparam int LANE_W       = 32;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_SEL_W    = 3;
  localparam int NUM_CFG_REGS = 8;
  localparam int NUM_PLANES   = 6;
  localparam int NUM_AXES     = 3;
  localparam int NUM_COMPS    = 4;
  localparam int OFFSET_COMP  = 3;
  localparam int CLIP_ROW     = 3;

endpackage

FILE: src/fbv_planes.sv
module fbv_planes #(
  parameter int COORD_WIDTH = 32
) (
  input  logic [fbv_pkg::CFG_DATA_W-1:0] mat      [fbv_pkg::NUM_CFG_REGS],
  output logic signed [COORD_WIDTH:0]    plane    [fbv_pkg::NUM_PLANES][fbv_pkg::NUM_COMPS]
);

  localparam int NW = COORD_WIDTH + 1;

  logic signed [NW-1:0] entry [fbv_pkg::NUM_COMPS][fbv_pkg::NUM_COMPS];

  always_comb begin
    for (int r = 0; r < fbv_pkg::NUM_COMPS; r++) begin
      for (int c = 0; c < fbv_pkg::NUM_COMPS; c++) begin
        logic [fbv_pkg::CFG_DATA_W-1:0] word;
        logic [fbv_pkg::LANE_W-1:0]     lane;
        word = mat[r * 2 + c / 2];
        lane = ((c % 2) == 1) ? word[2*fbv_pkg::LANE_W-1:fbv_pkg::LANE_W]
                              : word[fbv_pkg::LANE_W-1:0];
        entry[r][c] = {lane[COORD_WIDTH-1], lane[COORD_WIDTH-1:0]};
      end
    end
  end

  always_comb begin
    for (int p = 0; p < fbv_pkg::NUM_PLANES; p++) begin
      for (int k = 0; k < fbv_pkg::NUM_COMPS; k++) begin
        if ((p % 2) == 1) begin
          plane[p][k] = entry[fbv_pkg::CLIP_ROW][k] - entry[p / 2][k];
        end else begin
          plane[p][k] = entry[fbv_pkg::CLIP_ROW][k] + entry[p / 2][k];
        end
      end
    end
  end

endmodule

FILE: src/fbv_plane_test.sv
module fbv_plane_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic signed [COORD_WIDTH:0]    normal [fbv_pkg::NUM_COMPS],
  input  logic signed [COORD_WIDTH-1:0]  box_lo [fbv_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]  box_hi [fbv_pkg::NUM_AXES],
  output logic                           outside
);

  localparam int NW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 1;
  localparam int OW = NW + FRAC_BITS;
  localparam int MW = (PW > OW) ? PW : OW;
  localparam int SW = MW + 2;

  logic signed [NW-1:0]          n_r    [fbv_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] v_r    [fbv_pkg::NUM_AXES];
  logic signed [NW-1:0]          w_r;
  logic signed [PW-1:0]          prod_nxt [fbv_pkg::NUM_AXES];
  logic signed [PW-1:0]          prod_r   [fbv_pkg::NUM_AXES];
  logic signed [OW-1:0]          off_nxt;
  logic signed [OW-1:0]          off_r;
  logic signed [SW-1:0]          term   [fbv_pkg::NUM_COMPS];
  logic signed [SW-1:0]          sum;

  // pick the positive vertex per axis
  always_ff @(posedge clk) begin
    for (int k = 0; k < fbv_pkg::NUM_AXES; k++) begin
      n_r[k] <= normal[k];
      v_r[k] <= normal[k][NW-1] ? box_lo[k] : box_hi[k];
    end
    w_r <= normal[fbv_pkg::OFFSET_COMP];
  end

  always_comb begin
    for (int k = 0; k < fbv_pkg::NUM_AXES; k++) begin
      logic signed [PW-1:0] a_ext;
      logic signed [PW-1:0] b_ext;
      a_ext = {{(PW-NW){n_r[k][NW-1]}}, n_r[k]};
      b_ext = {{(PW-COORD_WIDTH){v_r[k][COORD_WIDTH-1]}}, v_r[k]};
      prod_nxt[k] = a_ext * b_ext;
    end
    off_nxt = {w_r, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fbv_pkg::NUM_AXES; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    off_r <= off_nxt;
  end

  always_comb begin
    for (int k = 0; k < fbv_pkg::NUM_AXES; k++) begin
      term[k] = {{(SW-PW){prod_r[k][PW-1]}}, prod_r[k]};
    end
    term[fbv_pkg::OFFSET_COMP] = {{(SW-OW){off_r[OW-1]}}, off_r};
    sum = term[0] + term[1] + term[2] + term[3];
  end

  assign outside = sum[SW-1];

endmodule

FILE: src/frustum_box_visibility_unit.sv
// out_valid is registered and rises once an accepted request has passed the stages listed below.
// Throughput: one box per cycle; busy stays low, start may be high every cycle.
// Stages: input register, vertex select, per-plane products, plane sums with result.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_n low, synchronous) clears the matrix registers and all valid flags.
module frustum_box_visibility_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [fbv_pkg::FIELD_W-1:0] in_box_min_x,
  input  logic signed [fbv_pkg::FIELD_W-1:0] in_box_min_y,
  input  logic signed [fbv_pkg::FIELD_W-1:0] in_box_min_z,
  input  logic signed [fbv_pkg::FIELD_W-1:0] in_box_max_x,
  input  logic signed [fbv_pkg::FIELD_W-1:0] in_box_max_y,
  input  logic signed [fbv_pkg::FIELD_W-1:0] in_box_max_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fbv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbv_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  output logic                               out_visible
);

  localparam int NW = COORD_WIDTH + 1;

  logic [fbv_pkg::CFG_DATA_W-1:0] mat_r [fbv_pkg::NUM_CFG_REGS];
  logic signed [COORD_WIDTH-1:0]  lo_r  [fbv_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0]  hi_r  [fbv_pkg::NUM_AXES];
  logic signed [NW-1:0]           plane [fbv_pkg::NUM_PLANES][fbv_pkg::NUM_COMPS];
  logic [fbv_pkg::NUM_PLANES-1:0] outside;
  logic                           in_vld_r;
  logic                           sel_vld_r;
  logic                           prod_vld_r;
  logic                           out_valid_r;
  logic                           out_visible_r;
  logic                           accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fbv_pkg::NUM_CFG_REGS; i++) begin
        mat_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < fbv_pkg::CFG_IDX_W'(fbv_pkg::NUM_CFG_REGS))) begin
      mat_r[cfg_index[fbv_pkg::CFG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // hold the request corners
  always_ff @(posedge clk) begin
    if (accept) begin
      lo_r[0] <= in_box_min_x[COORD_WIDTH-1:0];
      lo_r[1] <= in_box_min_y[COORD_WIDTH-1:0];
      lo_r[2] <= in_box_min_z[COORD_WIDTH-1:0];
      hi_r[0] <= in_box_max_x[COORD_WIDTH-1:0];
      hi_r[1] <= in_box_max_y[COORD_WIDTH-1:0];
      hi_r[2] <= in_box_max_z[COORD_WIDTH-1:0];
    end
  end

  fbv_planes #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_planes (
    .mat   (mat_r),
    .plane (plane)
  );

  for (genvar p = 0; p < fbv_pkg::NUM_PLANES; p++) begin : g_plane
    fbv_plane_test #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_test (
      .clk     (clk),
      .normal  (plane[p]),
      .box_lo  (lo_r),
      .box_hi  (hi_r),
      .outside (outside[p])
    );
  end

  // advance the valid flags alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      sel_vld_r   <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_vld_r    <= accept;
      sel_vld_r   <= in_vld_r;
      prod_vld_r  <= sel_vld_r;
      out_valid_r <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= ~|outside;
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule
